>>> design/lpk_pkg.sv
// Package for the length-prefixed key decoder.
// Holds phase and status codes, register indexes and widths.
// No dependencies.
package lpk_pkg;

    localparam int PREFIX_MAX_BYTES_DEF = 8;
    localparam int SIZE_WIDTH_DEF       = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int POS_W      = 4;
    localparam int MAXSZ_W    = 16;
    localparam int SEG_W      = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_BYTES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEG_SIZE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEGMENTS  = 3'd4;

    localparam logic [7:0]         SEPARATOR_RST = 8'd58;
    localparam logic [MAXSZ_W-1:0] MAX_SEG_SIZE_RST = 16'd256;
    localparam logic [SEG_W-1:0]   MAX_SEGMENTS_RST = 8'd32;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam int         DEC_BASE = 10;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_PREFIX = 3'd1,
        ST_BAD_SIZE   = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_TOO_LARGE  = 3'd4,
        ST_TRUNCATED  = 3'd5,
        ST_TOO_MANY   = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        PH_PREFIX  = 2'd0,
        PH_SIZE    = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_DRAIN   = 2'd3
    } t_phase;

endpackage

>>> design/lpk_in_if.sv
// Input channel of the key decoder: one encoded key byte per item.
// No dependencies.
interface lpk_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

>>> design/lpk_out_if.sv
// Result channel of the key decoder: payload byte and key completion status.
// No dependencies.
interface lpk_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       payload_valid;
    logic [7:0] segment_index;
    logic       segment_end;
    logic       done_res;
    logic [2:0] status;
    logic [7:0] segment_count;

    modport source (output valid, output out_byte, output payload_valid,
                    output segment_index, output segment_end, output done_res,
                    output status, output segment_count, input ready);
    modport sink   (input valid, input out_byte, input payload_valid,
                    input segment_index, input segment_end, input done_res,
                    input status, input segment_count, output ready);
endinterface

>>> design/length_prefixed_key_decoder_unit.sv
// Length-prefixed key decoder, top level.
// Depends on lpk_pkg, lpk_in_if and lpk_out_if.
//
// Decodes one key byte per clock: prefix check, decimal segment lengths ended
// by the separator, then payload bytes tagged with their segment index. A byte
// accepted at one edge has its result (if any) in the output register from the
// next cycle on. The per-byte parse is a single pass of shallow logic into that
// register; input ready drops only while the output register is full and the
// sink holds it. Prefix, digit and separator bytes give no result unless the
// key ends or fails on them; after an error, bytes are dropped up to in_last.
module length_prefixed_key_decoder_unit
    import lpk_pkg::*;
#(
    parameter int PREFIX_MAX_BYTES = PREFIX_MAX_BYTES_DEF,
    parameter int SIZE_WIDTH       = SIZE_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lpk_in_if.sink                i_in,
    lpk_out_if.source             o_out
);

    localparam int PIW = (PREFIX_MAX_BYTES > 1) ? $clog2(PREFIX_MAX_BYTES) : 1;
    localparam int CW  = (SIZE_WIDTH > MAXSZ_W) ? SIZE_WIDTH : MAXSZ_W;
    localparam int PW  = SIZE_WIDTH + 4;

    // configuration
    logic [CFG_DATA_W-1:0] r_prefix_bytes;
    logic [POS_W-1:0]      r_prefix_length;
    logic [7:0]            r_separator;
    logic [MAXSZ_W-1:0]    r_max_seg_size;
    logic [SEG_W-1:0]      r_max_segments;

    // parse state
    t_phase                r_phase, n_phase;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [SIZE_WIDTH-1:0] r_acc, n_acc;
    logic                  r_has, n_has;
    logic [SIZE_WIDTH-1:0] r_rem, n_rem;
    logic [SEG_W-1:0]      r_segs, n_segs;

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_payload_valid;
    logic [7:0] r_segment_index;
    logic       r_segment_end;
    logic       r_done;
    t_status    r_status;
    logic [7:0] r_segment_count;

    logic       n_emit;
    logic [7:0] n_out_byte;
    logic       n_payload_valid;
    logic [7:0] n_segment_index;
    logic       n_segment_end;
    logic       n_done;
    t_status    n_status;
    logic [7:0] n_segment_count;

    logic                  in_acc;
    logic [POS_W-1:0]      plen;
    logic [POS_W-1:0]      pos_inc;
    logic [7:0]            expect_byte;
    logic                  is_digit;
    logic [3:0]            digit;
    logic [PW-1:0]         prod;
    logic                  size_ovf;
    logic [SIZE_WIDTH-1:0] rem_dec;
    t_phase                eff_phase;
    logic                  fin;
    t_status               fin_st;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;

    assign plen = (r_prefix_length > POS_W'(PREFIX_MAX_BYTES)) ?
                  POS_W'(PREFIX_MAX_BYTES) : r_prefix_length;
    assign pos_inc     = r_pos + 1'b1;
    assign expect_byte = r_prefix_bytes[8 * r_pos[PIW-1:0] +: 8];
    assign is_digit    = (i_in.in_byte >= CH_ZERO) && (i_in.in_byte <= CH_NINE);
    assign digit       = 4'(i_in.in_byte - CH_ZERO);
    // acc * 10 + d, overflow when it leaves SIZE_WIDTH bits
    assign prod        = (PW'(r_acc) << 3) + (PW'(r_acc) << 1) + PW'(digit);
    assign size_ovf    = |prod[PW-1:SIZE_WIDTH];
    assign rem_dec     = (r_rem != '0) ? r_rem - 1'b1 : r_rem;
    assign eff_phase   = (r_phase == PH_PREFIX && r_pos >= plen) ? PH_SIZE : r_phase;

    always_comb begin
        n_phase         = r_phase;
        n_pos           = r_pos;
        n_acc           = r_acc;
        n_has           = r_has;
        n_rem           = r_rem;
        n_segs          = r_segs;
        n_emit          = 1'b0;
        n_out_byte      = '0;
        n_payload_valid = 1'b0;
        n_segment_index = '0;
        n_segment_end   = 1'b0;
        n_done          = 1'b0;
        n_status        = ST_OK;
        n_segment_count = '0;
        fin             = 1'b0;
        fin_st          = ST_OK;

        unique case (eff_phase)
            PH_DRAIN: begin
                if (i_in.in_last) begin
                    n_phase = PH_PREFIX;
                    n_pos   = '0;
                    n_acc   = '0;
                    n_has   = 1'b0;
                    n_rem   = '0;
                    n_segs  = '0;
                end
            end
            PH_PREFIX: begin
                if (i_in.in_byte != expect_byte) begin
                    fin    = 1'b1;
                    fin_st = ST_BAD_PREFIX;
                end else begin
                    n_pos = pos_inc;
                    if (i_in.in_last) begin
                        fin    = 1'b1;
                        fin_st = (pos_inc < plen) ? ST_BAD_PREFIX : ST_OK;
                    end
                end
            end
            PH_SIZE: begin
                n_phase = PH_SIZE;
                if (i_in.in_byte == r_separator) begin
                    if (!r_has) begin
                        fin    = 1'b1;
                        fin_st = ST_BAD_SIZE;
                    end else if (r_acc == '0) begin
                        fin    = 1'b1;
                        fin_st = ST_EMPTY;
                    end else if (CW'(r_acc) > CW'(r_max_seg_size)) begin
                        fin    = 1'b1;
                        fin_st = ST_TOO_LARGE;
                    end else begin
                        n_rem   = r_acc;
                        n_phase = PH_PAYLOAD;
                        if (i_in.in_last) begin
                            fin    = 1'b1;
                            fin_st = ST_TRUNCATED;
                        end
                    end
                end else if (is_digit) begin
                    if (size_ovf) begin
                        fin    = 1'b1;
                        fin_st = ST_TOO_LARGE;
                    end else begin
                        n_acc = prod[SIZE_WIDTH-1:0];
                        n_has = 1'b1;
                        if (i_in.in_last) begin
                            fin    = 1'b1;
                            fin_st = ST_BAD_SIZE;
                        end
                    end
                end else begin
                    fin    = 1'b1;
                    fin_st = ST_BAD_SIZE;
                end
            end
            PH_PAYLOAD: begin
                n_emit          = 1'b1;
                n_out_byte      = i_in.in_byte;
                n_payload_valid = 1'b1;
                n_segment_index = r_segs;
                n_rem           = rem_dec;
                if (rem_dec == '0) begin
                    n_segment_end = 1'b1;
                    if (r_segs >= r_max_segments) begin
                        fin    = 1'b1;
                        fin_st = ST_TOO_MANY;
                    end else begin
                        n_segs  = r_segs + 1'b1;
                        n_phase = PH_SIZE;
                        n_acc   = '0;
                        n_has   = 1'b0;
                        if (i_in.in_last) begin
                            fin    = 1'b1;
                            fin_st = ST_OK;
                        end
                    end
                end else if (i_in.in_last) begin
                    fin    = 1'b1;
                    fin_st = ST_TRUNCATED;
                end
            end
            default: ;
        endcase

        if (fin) begin
            n_emit          = 1'b1;
            n_done          = 1'b1;
            n_status        = fin_st;
            n_segment_count = n_segs;
            if (i_in.in_last) begin
                n_phase = PH_PREFIX;
                n_pos   = '0;
                n_acc   = '0;
                n_has   = 1'b0;
                n_rem   = '0;
                n_segs  = '0;
            end else begin
                n_phase = PH_DRAIN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix_bytes  <= '0;
            r_prefix_length <= '0;
            r_separator     <= SEPARATOR_RST;
            r_max_seg_size  <= MAX_SEG_SIZE_RST;
            r_max_segments  <= MAX_SEGMENTS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PREFIX_BYTES:  r_prefix_bytes  <= i_cfg_data;
                CFG_PREFIX_LENGTH: r_prefix_length <= i_cfg_data[POS_W-1:0];
                CFG_SEPARATOR:     r_separator     <= i_cfg_data[7:0];
                CFG_MAX_SEG_SIZE:  r_max_seg_size  <= i_cfg_data[MAXSZ_W-1:0];
                CFG_MAX_SEGMENTS:  r_max_segments  <= i_cfg_data[SEG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_PREFIX;
            r_pos       <= '0;
            r_acc       <= '0;
            r_has       <= 1'b0;
            r_rem       <= '0;
            r_segs      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_acc   <= n_acc;
                r_has   <= n_has;
                r_rem   <= n_rem;
                r_segs  <= n_segs;
            end
            if (in_acc && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && n_emit) begin
            r_out_byte      <= n_out_byte;
            r_payload_valid <= n_payload_valid;
            r_segment_index <= n_segment_index;
            r_segment_end   <= n_segment_end;
            r_done          <= n_done;
            r_status        <= n_status;
            r_segment_count <= n_segment_count;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_byte      = r_out_byte;
    assign o_out.payload_valid = r_payload_valid;
    assign o_out.segment_index = r_segment_index;
    assign o_out.segment_end   = r_segment_end;
    assign o_out.done_res      = r_done;
    assign o_out.status        = r_status;
    assign o_out.segment_count = r_segment_count;

endmodule

>>> sim/lpk_decode_checker.sv
`timescale 1ns / 100ps
// Result checker for the length-prefixed key decoder: mirrors the register port,
// predicts the decoder output for every accepted key byte and compares results.
// Depends on lpk_pkg, lpk_in_if and lpk_out_if.
module lpk_decode_checker
    import lpk_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lpk_in_if                     i_in,
    lpk_out_if                    i_out,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_checked
);

    localparam int unsigned SIZE_LIMIT = (1 << SIZE_WIDTH_DEF) - 1;

    typedef struct packed {
        logic [7:0] data;
        logic       pay;
        logic [7:0] seg_idx;
        logic       seg_end;
        logic       done;
        t_status    st;
        logic [7:0] seg_cnt;
    } t_key_result;

    logic [CFG_DATA_W-1:0] cfg_prefix;
    logic [POS_W-1:0]      cfg_prefix_len;
    logic [7:0]            cfg_sep;
    logic [MAXSZ_W-1:0]    cfg_max_size;
    logic [SEG_W-1:0]      cfg_max_segs;

    t_phase      parse_phase;
    int unsigned prefix_pos;
    int unsigned size_acc;
    logic        size_seen;
    int unsigned bytes_left;
    logic [7:0]  segs_done;

    t_key_result expected_results[$];
    t_key_result got;
    t_key_result want;
    int          mismatches;
    int          checked;

    function automatic string fmt_result(input t_key_result r);
        return $sformatf("byte=%h pay=%b seg=%0d end=%b done=%b status=%0d count=%0d",
                         r.data, r.pay, r.seg_idx, r.seg_end, r.done, r.st, r.seg_cnt);
    endfunction

    task automatic post_expected(input t_key_result r);
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic restart_key();
        parse_phase = PH_PREFIX;
        prefix_pos  = 0;
        size_acc    = 0;
        size_seen   = 1'b0;
        bytes_left  = 0;
        segs_done   = '0;
    endtask

    task automatic key_end(input t_key_result r, input t_status st, input logic last);
        r.done    = 1'b1;
        r.st      = st;
        r.seg_cnt = segs_done;
        post_expected(r);
        if (last) begin
            restart_key();
        end else begin
            parse_phase = PH_DRAIN;
        end
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic last);
        t_key_result r;
        int unsigned plen;
        int unsigned dval;
        r = '0;
        if (parse_phase == PH_DRAIN) begin
            if (last) begin
                restart_key();
            end
            return;
        end
        if (parse_phase == PH_PREFIX) begin
            plen = (cfg_prefix_len > PREFIX_MAX_BYTES_DEF) ? PREFIX_MAX_BYTES_DEF
                                                           : cfg_prefix_len;
            if (prefix_pos < plen) begin
                if (b != cfg_prefix[8*prefix_pos +: 8]) begin
                    key_end(r, ST_BAD_PREFIX, last);
                    return;
                end
                prefix_pos++;
                if (last) begin
                    key_end(r, (prefix_pos < plen) ? ST_BAD_PREFIX : ST_OK, 1'b1);
                end
                return;
            end
            parse_phase = PH_SIZE;
        end
        if (parse_phase == PH_SIZE) begin
            // separator wins even when it is a digit
            if (b == cfg_sep) begin
                if (!size_seen) begin
                    key_end(r, ST_BAD_SIZE, last);
                end else if (size_acc == 0) begin
                    key_end(r, ST_EMPTY, last);
                end else if (size_acc > cfg_max_size) begin
                    key_end(r, ST_TOO_LARGE, last);
                end else begin
                    bytes_left  = size_acc;
                    parse_phase = PH_PAYLOAD;
                    if (last) begin
                        key_end(r, ST_TRUNCATED, 1'b1);
                    end
                end
            end else if (b >= CH_ZERO && b <= CH_NINE) begin
                dval = 32'(b - CH_ZERO);
                if (size_acc > (SIZE_LIMIT - dval) / DEC_BASE) begin
                    key_end(r, ST_TOO_LARGE, last);
                end else begin
                    size_acc  = size_acc * DEC_BASE + dval;
                    size_seen = 1'b1;
                    if (last) begin
                        key_end(r, ST_BAD_SIZE, 1'b1);
                    end
                end
            end else begin
                key_end(r, ST_BAD_SIZE, last);
            end
            return;
        end
        r.data    = b;
        r.pay     = 1'b1;
        r.seg_idx = segs_done;
        if (bytes_left > 0) begin
            bytes_left--;
        end
        if (bytes_left == 0) begin
            r.seg_end = 1'b1;
            if (segs_done >= cfg_max_segs) begin
                key_end(r, ST_TOO_MANY, last);
                return;
            end
            segs_done++;
            parse_phase = PH_SIZE;
            size_acc    = 0;
            size_seen   = 1'b0;
            if (last) begin
                key_end(r, ST_OK, 1'b1);
            end else begin
                post_expected(r);
            end
        end else if (last) begin
            key_end(r, ST_TRUNCATED, 1'b1);
        end else begin
            post_expected(r);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_prefix     = '0;
            cfg_prefix_len = '0;
            cfg_sep        = SEPARATOR_RST;
            cfg_max_size   = MAX_SEG_SIZE_RST;
            cfg_max_segs   = MAX_SEGMENTS_RST;
            restart_key();
            expected_results.delete();
            mismatches = 0;
            checked    = 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                got.data    = i_out.out_byte;
                got.pay     = i_out.payload_valid;
                got.seg_idx = i_out.segment_index;
                got.seg_end = i_out.segment_end;
                got.done    = i_out.done_res;
                got.st      = t_status'(i_out.status);
                got.seg_cnt = i_out.segment_count;
                checked++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR result %0d unexpected: got %s", checked,
                                 fmt_result(got));
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("ERROR result %0d: expected %s", checked,
                                     fmt_result(want));
                            $display("ERROR result %0d:      got %s", checked,
                                     fmt_result(got));
                        end
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                predict_byte(i_in.in_byte, i_in.in_last);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PREFIX_BYTES:  cfg_prefix     = i_cfg_data;
                    CFG_PREFIX_LENGTH: cfg_prefix_len = i_cfg_data[POS_W-1:0];
                    CFG_SEPARATOR:     cfg_sep        = i_cfg_data[7:0];
                    CFG_MAX_SEG_SIZE:  cfg_max_size   = i_cfg_data[MAXSZ_W-1:0];
                    CFG_MAX_SEGMENTS:  cfg_max_segs   = i_cfg_data[SEG_W-1:0];
                    default: ;
                endcase
            end
        end
        o_errors  <= mismatches;
        o_pending <= expected_results.size();
        o_checked <= checked;
    end

endmodule

>>> sim/tb_length_prefixed_key_decoder_unit.sv
`timescale 1ns / 100ps
// Testbench top for length_prefixed_key_decoder_unit: resets the decoder, sends
// directed and random encoded keys under several register settings, gives the verdict.
// Depends on lpk_pkg, lpk_in_if, lpk_out_if, the decoder and lpk_decode_checker.
module tb_length_prefixed_key_decoder_unit
    import lpk_pkg::*;
();

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lpk_in_if  in_ch ();
    lpk_out_if out_ch ();

    int chk_errors;
    int chk_pending;
    int chk_checked;

    logic [63:0] prefix_val;
    int unsigned prefix_len;
    logic [7:0]  sep_val;
    int unsigned max_size;
    int unsigned max_segs;

    logic [7:0] key_bytes[$];
    int         bytes_sent;
    int         keys_sent;
    int         settings_used;
    int         burst_left;

    length_prefixed_key_decoder_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    lpk_decode_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .i_out      (out_ch),
        .o_errors   (chk_errors),
        .o_pending  (chk_pending),
        .o_checked  (chk_checked)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : receiver
        int mode;
        int span;
        out_ch.ready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 96);
            repeat (span) begin
                @(posedge i_clk);
                case (mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= 1'($urandom_range(0, 1));
                    2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: out_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic wait_idle();
        int n;
        n = 0;
        in_ch.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (chk_pending != 0 && n < 20000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [POS_W-1:0] plen, input logic [63:0] pbytes,
                              input logic [7:0] sep, input logic [MAXSZ_W-1:0] msz,
                              input logic [SEG_W-1:0] mseg);
        logic [63:0] junk;
        wait_idle();
        // unused upper data bits must be ignored
        junk = ($urandom_range(0, 1) == 1) ? {$urandom, $urandom} : '0;
        prefix_len = 32'(plen);
        prefix_val = pbytes;
        sep_val    = sep;
        max_size   = 32'(msz);
        max_segs   = 32'(mseg);
        write_reg(CFG_PREFIX_BYTES, pbytes);
        write_reg(CFG_PREFIX_LENGTH, {junk[63:POS_W], plen});
        write_reg(CFG_SEPARATOR, {junk[63:8], sep});
        write_reg(CFG_MAX_SEG_SIZE, {junk[63:MAXSZ_W], msz});
        write_reg(CFG_MAX_SEGMENTS, {junk[63:SEG_W], mseg});
        write_reg(CFG_MAX_SEGMENTS + 3'($urandom_range(1, 3)), {$urandom, $urandom});
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic add_key_byte(input logic [7:0] b);
        key_bytes.insert(key_bytes.size(), b);
    endtask

    task automatic send_key();
        foreach (key_bytes[i]) push_byte(key_bytes[i], i == key_bytes.size() - 1);
        key_bytes.delete();
        keys_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) add_key_byte(s[i]);
        send_key();
    endtask

    task automatic append_prefix();
        for (int i = 0; i < prefix_len && i < PREFIX_MAX_BYTES_DEF; i++) begin
            add_key_byte(prefix_val[8*i +: 8]);
        end
    endtask

    task automatic append_size(input int unsigned n);
        logic [7:0] digits[$];
        do begin
            digits.push_front(8'(CH_ZERO + n % DEC_BASE));
            n = n / DEC_BASE;
        end while (n != 0);
        if ($urandom_range(0, 15) == 0) begin
            add_key_byte(CH_ZERO);
        end
        foreach (digits[i]) add_key_byte(digits[i]);
    endtask

    task automatic build_good_key(input int nseg);
        int unsigned len;
        int unsigned top_len;
        top_len = (max_size < 10) ? max_size : 10;
        append_prefix();
        repeat (nseg) begin
            len = ($urandom_range(0, 9) == 0) ? ((max_size < 40) ? max_size : 40)
                                              : $urandom_range(1, top_len);
            append_size(len);
            add_key_byte(sep_val);
            repeat (len) add_key_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : stimulus
        int         kind;
        int         nseg;
        int         cut;
        int         pos;
        int         phase_start;
        int         fails;
        logic [7:0] b;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_PREFIX_BYTES;
        i_cfg_data    <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= '0;
        in_ch.in_last <= 1'b0;
        prefix_val    = '0;
        prefix_len    = 0;
        sep_val       = SEPARATOR_RST;
        max_size      = 32'(MAX_SEG_SIZE_RST);
        max_segs      = 32'(MAX_SEGMENTS_RST);
        bytes_sent    = 0;
        keys_sent     = 0;
        settings_used = 1;
        burst_left    = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed keys under reset settings, then with a two-byte prefix
        send_text(":");
        send_text("0:");
        send_text("1:A");
        send_text("x");
        send_text("65536z");
        send_text("2:a");
        send_text("1:");
        send_text("3");
        set_config(4'd2, 64'h4241, SEPARATOR_RST, MAX_SEG_SIZE_RST, MAX_SEGMENTS_RST);
        send_text("A");
        send_text("AB");
        send_text("AX");

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: set_config(4'd0, {$urandom, $urandom}, SEPARATOR_RST,
                              MAX_SEG_SIZE_RST, MAX_SEGMENTS_RST);
                1: set_config(4'd8, {$urandom, $urandom}, SEPARATOR_RST, 16'd1, 8'd1);
                2: set_config(4'd15, {$urandom, $urandom}, 8'h00, 16'hFFFF, 8'd255);
                3: set_config(4'd3, {$urandom, $urandom}, 8'hFF, 16'd12, 8'd3);
                4: set_config(4'd1, {$urandom, $urandom}, CH_ZERO + 8'd5, 16'd20, 8'd4);
                default: set_config(4'($urandom_range(0, 15)), {$urandom, $urandom},
                             ($urandom_range(0, 9) < 7) ? SEPARATOR_RST
                                                        : 8'($urandom_range(0, 255)),
                             ($urandom_range(0, 7) == 0) ? 16'hFFFF
                                                         : 16'($urandom_range(1, 30)),
                             ($urandom_range(0, 7) == 0) ? 8'd255
                                                         : 8'($urandom_range(1, 8)));
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 120) begin
                kind = $urandom_range(0, 99);
                nseg = $urandom_range(1, (max_segs < 4) ? max_segs : 4);
                if (kind < 55) begin
                    build_good_key(nseg);
                end else if (kind < 65) begin
                    build_good_key(nseg);
                    cut = $urandom_range(1, key_bytes.size());
                    while (key_bytes.size() > cut) key_bytes.delete(key_bytes.size() - 1);
                end else if (kind < 75) begin
                    build_good_key(nseg);
                    key_bytes[$urandom_range(0, key_bytes.size() - 1)] =
                        8'($urandom_range(0, 255));
                end else if (kind < 81) begin
                    build_good_key((max_segs < 8) ? max_segs + 1 : nseg);
                end else if (kind < 90) begin
                    append_prefix();
                    case ($urandom_range(0, 4))
                        0: append_size(0);
                        1: ;
                        2: append_size(max_size + 1);
                        3: append_size($urandom_range(65536, 99999));
                        default: begin
                            append_size($urandom_range(1, 9));
                            do b = 8'($urandom_range(0, 255));
                            while ((b >= CH_ZERO && b <= CH_NINE) || b == sep_val);
                            add_key_byte(b);
                        end
                    endcase
                    add_key_byte(sep_val);
                    // trailing bytes land after the error
                    repeat ($urandom_range(0, 4)) add_key_byte(8'($urandom_range(0, 255)));
                end else if (kind < 95 && prefix_len > 0) begin
                    build_good_key(nseg);
                    pos = $urandom_range(0, ((prefix_len < PREFIX_MAX_BYTES_DEF) ? prefix_len
                                             : PREFIX_MAX_BYTES_DEF) - 1);
                    key_bytes[pos] = key_bytes[pos] ^ (8'd1 << $urandom_range(0, 7));
                end else begin
                    repeat ($urandom_range(1, 6)) add_key_byte(8'($urandom_range(0, 255)));
                end
                send_key();
            end
        end

        wait_idle();
        fails = chk_errors + chk_pending;
        $display("Sent %0d key bytes in %0d keys under %0d register settings.",
                 bytes_sent, keys_sent, settings_used);
        $display("Compared %0d decoder results, %0d failures.", chk_checked, fails);
        if (fails == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
